/* sv/assert_macros.svh */
// Assertion macros shared by the console checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define TCW_ASSERT(lbl, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds across reset
`define TCW_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tcw_pkg.sv */
// Types, codes and constants for the text console writer.
// No dependencies; used by every module of the block by scoped names.
package tcw_pkg;

  // Fixed field widths of the ports
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;
  localparam int ADDR_W = 11;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CLR_W-1:0]  color_t;
  typedef logic [4:0]        row_out_t;
  typedef logic [6:0]        col_out_t;
  typedef logic [ADDR_W-1:0] lin_out_t;
  typedef logic [1:0]        cfg_idx_t;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control characters
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;

  // Configuration register indexes
  localparam cfg_idx_t CFG_TEXT_HI  = 2'd0;
  localparam cfg_idx_t CFG_TEXT_LO  = 2'd1;
  localparam cfg_idx_t CFG_BLANK_HI = 2'd2;
  localparam cfg_idx_t CFG_BLANK_LO = 2'd3;

  // Reset colors
  localparam color_t RST_HI = 4'h0;
  localparam color_t RST_LO = 4'h7;

  // Cell written by the clearing pass after reset
  localparam cell_t CLEAR_CELL = {RST_HI, RST_LO, CH_SPACE};

  typedef struct packed {
    color_t text_hi;
    color_t text_lo;
    color_t blank_hi;
    color_t blank_lo;
  } colors_t;

  typedef struct packed {
    cell_t    cell_data;
    row_out_t cursor_row;
    col_out_t cursor_column;
    lin_out_t cursor_linear;
    char_t    echo_char;
    logic     echo_valid;
  } result_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_t;

  function automatic cell_t pack_cell(char_t ch, color_t hi, color_t lo);
    return {hi, lo, ch};
  endfunction

endpackage

/* sv/tcw_fbuf.sv */
// Frame buffer memory: one write port, one registered read port.
// Depends on tcw_pkg for the cell type.
module tcw_fbuf #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  tcw_pkg::cell_t wdata,
  input  logic [AW-1:0]  raddr,
  output tcw_pkg::cell_t rdata
);

  tcw_pkg::cell_t mem [DEPTH];
  tcw_pkg::cell_t rdata_r;

  // Write one cell per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data follows the address in the next cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/tcw_seq.sv */
// Console sequencer: cursor, put/read handling, clearing pass and scroll copy.
// Depends on tcw_pkg; drives the frame buffer ports of tcw_fbuf.
module tcw_seq #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4,
  parameter int CELLS    = 2000,
  parameter int AW       = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  tcw_pkg::char_t           in_char_code,
  input  logic [tcw_pkg::ADDR_W-1:0] in_cell_address,
  input  tcw_pkg::colors_t         colors,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output tcw_pkg::cell_t           mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  tcw_pkg::cell_t           mem_rdata,
  output logic                     res_valid,
  output tcw_pkg::result_t         res
);

  localparam int CW       = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int COPY_END = CELLS - COLS;

  tcw_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [PW-1:0]    ph_r, ph_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             pend_copy_r, pend_copy_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  tcw_pkg::char_t   rd_char_r, rd_char_nxt;
  logic             res_valid_r, res_valid_nxt;
  tcw_pkg::result_t res_r, res_nxt;

  logic        accept;
  logic        is_nl, is_cr, is_tab;
  logic        adv;
  logic        scroll;
  logic [31:0] row32, col32, ph32, ptr32;
  logic [31:0] tab_col, prt_col, prt_ph;
  logic [31:0] col_n32, ph_n32, row_n32, row_inc;
  logic [31:0] cur_lin, nxt_lin, rd_addr32, src32;
  tcw_pkg::cell_t blank;

  assign accept    = start && (state_r == tcw_pkg::ST_IDLE);
  assign busy      = (state_r != tcw_pkg::ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign blank = tcw_pkg::pack_cell(tcw_pkg::CH_SPACE, colors.blank_hi, colors.blank_lo);

  // Widen cursor state for arithmetic
  assign row32     = 32'(row_r);
  assign col32     = 32'(col_r);
  assign ph32      = 32'(ph_r);
  assign ptr32     = 32'(ptr_r);
  assign rd_addr32 = 32'(in_cell_address);
  assign src32     = ptr32 + 32'(COLS);
  assign cur_lin   = row32 * 32'(COLS) + col32;

  assign is_nl  = (in_char_code == tcw_pkg::CH_NL);
  assign is_cr  = (in_char_code == tcw_pkg::CH_CR);
  assign is_tab = (in_char_code == tcw_pkg::CH_TAB);

  // Candidate columns; ph_r tracks the column modulo the tab stop
  assign tab_col = col32 + 32'(TAB_STOP) - ph32;
  assign prt_col = col32 + 32'd1;
  assign prt_ph  = (ph32 + 32'd1 == 32'(TAB_STOP)) ? 32'd0 : ph32 + 32'd1;

  // Cursor move of a put
  always_comb begin
    priority if (is_nl) begin
      col_n32 = '0;
      ph_n32  = '0;
      adv     = 1'b1;
    end else if (is_cr) begin
      col_n32 = '0;
      ph_n32  = '0;
      adv     = 1'b0;
    end else if (is_tab) begin
      adv     = (tab_col >= 32'(COLS));
      col_n32 = adv ? 32'd0 : tab_col;
      ph_n32  = '0;
    end else begin
      adv     = (prt_col >= 32'(COLS));
      col_n32 = adv ? 32'd0 : prt_col;
      ph_n32  = adv ? 32'd0 : prt_ph;
    end
  end

  assign row_inc = row32 + 32'd1;
  assign scroll  = adv && (row_inc >= 32'(ROWS));
  assign row_n32 = !adv ? row32 : (scroll ? 32'(ROWS - 1) : row_inc);
  assign nxt_lin = row_n32 * 32'(COLS) + col_n32;

  // Sequencer next state and memory port
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ph_nxt        = ph_r;
    pend_v_nxt    = 1'b0;
    pend_copy_nxt = pend_copy_r;
    pend_addr_nxt = pend_addr_r;
    rd_ok_nxt     = rd_ok_r;
    rd_char_nxt   = rd_char_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_lin[AW-1:0];
    mem_wdata     = tcw_pkg::pack_cell(in_char_code, colors.text_hi, colors.text_lo);
    mem_raddr     = rd_addr32[AW-1:0];

    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = tcw_pkg::CLEAR_CELL;
        if (ptr32 == 32'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_opcode == tcw_pkg::OP_PUT) begin
            // Store printable characters at the cursor, then move it
            mem_we  = !(is_nl || is_cr || is_tab);
            row_nxt = row_n32[RW-1:0];
            col_nxt = col_n32[CW-1:0];
            ph_nxt  = ph_n32[PW-1:0];
            res_valid_nxt         = 1'b1;
            res_nxt.cell_data     = '0;
            res_nxt.cursor_row    = tcw_pkg::row_out_t'(row_n32);
            res_nxt.cursor_column = tcw_pkg::col_out_t'(col_n32);
            res_nxt.cursor_linear = tcw_pkg::lin_out_t'(nxt_lin);
            res_nxt.echo_char     = in_char_code;
            res_nxt.echo_valid    = 1'b1;
            if (scroll) begin
              ptr_nxt   = '0;
              state_nxt = tcw_pkg::ST_SCROLL;
            end
          end else begin
            rd_ok_nxt   = (rd_addr32 < 32'(CELLS));
            rd_char_nxt = in_char_code;
            state_nxt   = tcw_pkg::ST_RDWAIT;
          end
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        res_valid_nxt         = 1'b1;
        res_nxt.cell_data     = rd_ok_r ? mem_rdata : '0;
        res_nxt.cursor_row    = tcw_pkg::row_out_t'(row32);
        res_nxt.cursor_column = tcw_pkg::col_out_t'(col32);
        res_nxt.cursor_linear = tcw_pkg::lin_out_t'(cur_lin);
        res_nxt.echo_char     = rd_char_r;
        res_nxt.echo_valid    = 1'b0;
        state_nxt             = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        // Read one row ahead of the destination; the write lands next cycle
        mem_raddr     = src32[AW-1:0];
        pend_v_nxt    = 1'b1;
        pend_addr_nxt = ptr_r;
        pend_copy_nxt = (ptr32 < 32'(COPY_END));
        if (ptr32 == 32'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = tcw_pkg::ST_DRAIN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      tcw_pkg::ST_DRAIN: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_CLEAR;
        ptr_nxt   = '0;
      end
    endcase

    // Retire the pending scroll write; reads stay a full row ahead of it
    if (pend_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = pend_copy_r ? mem_rdata : blank;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ph_r        <= '0;
      pend_v_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ph_r        <= ph_nxt;
      pend_v_r    <= pend_v_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_copy_r <= pend_copy_nxt;
    pend_addr_r <= pend_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_char_r   <= rd_char_nxt;
    res_r       <= res_nxt;
  end

endmodule

/* sv/text_console_writer.sv */
// Text console writer top level: configuration registers, sequencer, frame buffer.
// Depends on tcw_pkg, tcw_seq and tcw_fbuf.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | start / busy        | in_opcode, in_char_code, in_cell_address
//  result   | out_strobe (1 cyc)  | out_cell_data, out_cursor_*, out_echo_*
//  config   | cfg_we              | cfg_index, cfg_data
//
// After reset a clearing pass writes one cell per cycle over the whole screen
// with busy high; configuration writes are taken during it.
// A put's result strobes in the cycle after its acceptance; a read first passes
// through the RDWAIT state for the registered memory read.
// A put that leaves the bottom row adds a scroll pass over every cell, set by
// the single write port of the frame buffer (one cell moved per cycle), then DRAIN.
// The receiver cannot stall: every result is shown for exactly one cycle.
module text_console_writer #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [7:0]                   in_char_code,
  input  logic [10:0]                  in_cell_address,
  output logic                         out_strobe,
  output logic [15:0]                  out_cell_data,
  output logic [4:0]                   out_cursor_row,
  output logic [6:0]                   out_cursor_column,
  output logic [10:0]                  out_cursor_linear,
  output logic [7:0]                   out_echo_char,
  output logic                         out_echo_valid,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [3:0]                   cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::colors_t cfg_r, cfg_nxt;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  tcw_pkg::cell_t   mem_wdata;
  logic [AW-1:0]    mem_raddr;
  tcw_pkg::cell_t   mem_rdata;
  tcw_pkg::result_t res;

  // Configuration register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_TEXT_HI:  cfg_nxt.text_hi  = cfg_data;
        tcw_pkg::CFG_TEXT_LO:  cfg_nxt.text_lo  = cfg_data;
        tcw_pkg::CFG_BLANK_HI: cfg_nxt.blank_hi = cfg_data;
        tcw_pkg::CFG_BLANK_LO: cfg_nxt.blank_lo = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{text_hi: tcw_pkg::RST_HI, text_lo: tcw_pkg::RST_LO,
                 blank_hi: tcw_pkg::RST_HI, blank_lo: tcw_pkg::RST_LO};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcw_seq #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .CELLS    (CELLS),
    .AW       (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_char_code    (in_char_code),
    .in_cell_address (in_cell_address),
    .colors          (cfg_r),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .res_valid       (out_strobe),
    .res             (res)
  );

  tcw_fbuf #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_fbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result beat fields
  assign out_cell_data     = res.cell_data;
  assign out_cursor_row    = res.cursor_row;
  assign out_cursor_column = res.cursor_column;
  assign out_cursor_linear = res.cursor_linear;
  assign out_echo_char     = res.echo_char;
  assign out_echo_valid    = res.echo_valid;

endmodule

/* sv/tcw_chk.sv */
// Port-level checker for the text console writer, bound to the top level.
// Depends on assert_macros.svh and tcw_pkg.
`include "assert_macros.svh"

module tcw_chk #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_opcode,
  input logic       out_strobe,
  input logic [4:0] out_cursor_row,
  input logic [6:0] out_cursor_column,
  input logic       out_echo_valid
);

  logic put_acc;
  logic rd_acc;
  logic cur_ok;

  assign put_acc = start && !busy && (in_opcode == tcw_pkg::OP_PUT);
  assign rd_acc  = start && !busy && (in_opcode == tcw_pkg::OP_READ);
  assign cur_ok  = (32'(out_cursor_column) < 32'(COLS)) && (32'(out_cursor_row) < 32'(ROWS));

  // A put beat comes out in the next cycle, flagged as an echo
  `TCW_ASSERT(a_put_result, rst_n, put_acc |=> (out_strobe && out_echo_valid), "put result missing")

  // A read beat comes out after the registered memory read, without the echo flag
  `TCW_ASSERT(a_read_result, rst_n, rd_acc |=> (!out_strobe ##1 (out_strobe && !out_echo_valid)), "read result timing")

  // Reported cursor stays inside the screen
  `TCW_ASSERT(a_cursor_range, rst_n, out_strobe |-> cur_ok, "cursor out of range")

  // Reset starts the clearing pass
  `TCW_ASSERT_NR(a_clear_busy, !rst_n |=> busy, "not busy after reset")

endmodule

bind text_console_writer tcw_chk #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_opcode         (in_opcode),
  .out_strobe        (out_strobe),
  .out_cursor_row    (out_cursor_row),
  .out_cursor_column (out_cursor_column),
  .out_echo_valid    (out_echo_valid)
);

/* dv/text_console_writer_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the text console writer: a directed table, then bursts of
// console traffic under several color settings, checked against an in-bench model or typed-in results.
// Depends on tcw_pkg and text_console_writer.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int TAB_STOP    = 4;
  localparam int CELLS       = COLS * ROWS;
  localparam int PHASE_BEATS = 300;
  localparam int SCROLL_CAP  = 300;
  localparam int IDLE_PCT    = 19;
  localparam int NUM_PALS    = 6;
  localparam int DIR_ROWS    = 19;

  // One row of the directed table; the typed-in result is used when literal is set
  typedef struct packed {
    logic     op;
    char_t    ch;
    lin_out_t addr;
    logic     literal;
    cell_t    want_cell;
    row_out_t row;
    col_out_t col;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{OP_READ, 8'h00,     11'd0,    1'b1, CLEAR_CELL, 5'd0, 7'd0},
    '{OP_READ, 8'hFF,     11'd1999, 1'b1, CLEAR_CELL, 5'd0, 7'd0},
    '{OP_READ, 8'h00,     11'd2000, 1'b1, 16'h0000,   5'd0, 7'd0},
    '{OP_READ, 8'h5A,     11'd2047, 1'b1, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  8'h41,     11'd0,    1'b1, 16'h0000,   5'd0, 7'd1},
    '{OP_PUT,  8'hFF,     11'h7FF,  1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  8'h00,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_TAB,    11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_TAB,    11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_CR,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_READ, 8'h00,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_READ, 8'h00,     11'd2,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_NL,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_SPACE,  11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  8'h7F,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  8'h80,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_READ, 8'h00,     11'd80,   1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_READ, 8'h00,     11'd1,    1'b0, 16'h0000,   5'd0, 7'd0},
    '{OP_PUT,  CH_NL,     11'd0,    1'b0, 16'h0000,   5'd0, 7'd0}
  };

  logic     clk             = 1'b0;
  logic     rst_n           = 1'b0;
  logic     start           = 1'b0;
  logic     in_opcode       = OP_PUT;
  char_t    in_char_code    = '0;
  lin_out_t in_cell_address = '0;
  logic     cfg_we          = 1'b0;
  cfg_idx_t cfg_index       = CFG_TEXT_HI;
  color_t   cfg_data        = '0;

  logic     busy;
  logic     out_strobe;
  cell_t    out_cell_data;
  row_out_t out_cursor_row;
  col_out_t out_cursor_column;
  lin_out_t out_cursor_linear;
  char_t    out_echo_char;
  logic     out_echo_valid;

  // Shadow console: screen contents, cursor and current colors
  cell_t       screen [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  colors_t     pal;
  result_t     due_reports [$];
  bit          gaps_on;

  int errors      = 0;
  int beats_sent  = 0;
  int n_put       = 0;
  int n_read      = 0;
  int n_scroll    = 0;
  int n_tab_wrap  = 0;
  int n_bottom_nl = 0;
  int n_oob       = 0;

  text_console_writer #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .in_cell_address   (in_cell_address),
    .out_strobe        (out_strobe),
    .out_cell_data     (out_cell_data),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_cursor_linear (out_cursor_linear),
    .out_echo_char     (out_echo_char),
    .out_echo_valid    (out_echo_valid),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung handshake
  initial begin
    #30_000_000;
    $display("text_console_writer test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
  endtask

  // Apply one accepted beat to the shadow console and return its report
  function automatic result_t console_apply(logic op, char_t ch, lin_out_t addr);
    result_t     r;
    cell_t       blank;
    int unsigned i;
    r = '0;
    if (op == OP_PUT) begin
      n_put++;
      if (ch == CH_NL) begin
        if (cur_row == ROWS - 1) n_bottom_nl++;
        cur_col = 0;
        cur_row++;
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else if (ch == CH_TAB) begin
        cur_col += TAB_STOP - (cur_col % TAB_STOP);
        if (cur_col >= COLS) begin
          n_tab_wrap++;
          cur_col = 0;
          cur_row++;
        end
      end else begin
        screen[cur_row * COLS + cur_col] = {pal.text_hi, pal.text_lo, ch};
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Scroll up one row and blank the bottom row
      if (cur_row >= ROWS) begin
        n_scroll++;
        blank = {pal.blank_hi, pal.blank_lo, CH_SPACE};
        for (i = 0; i < COLS * (ROWS - 1); i++) screen[i] = screen[i + COLS];
        for (i = COLS * (ROWS - 1); i < CELLS; i++) screen[i] = blank;
        cur_row = ROWS - 1;
      end
    end else begin
      n_read++;
      if (addr < CELLS) r.cell_data = screen[addr];
      else n_oob++;
    end
    r.cursor_row    = row_out_t'(cur_row);
    r.cursor_column = col_out_t'(cur_col);
    r.cursor_linear = lin_out_t'(cur_row * COLS + cur_col);
    r.echo_char     = ch;
    r.echo_valid    = (op == OP_PUT);
    return r;
  endfunction

  // Drive one beat, wait for acceptance, then queue its report
  task automatic send_beat(input logic op, input char_t ch, input lin_out_t addr,
                           input bit literal, input result_t literal_res);
    result_t predicted;
    // Bound scrolls: past SCROLL_CAP, a bottom-row put that may scroll becomes a read
    if (op == OP_PUT && n_scroll >= SCROLL_CAP && cur_row == ROWS - 1 &&
        (ch == CH_NL || ch == CH_TAB || (ch != CH_CR && cur_col == COLS - 1))) begin
      op   = OP_READ;
      addr = lin_out_t'(cur_row * COLS + cur_col);
    end
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_char_code    <= ch;
    in_cell_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = console_apply(op, ch, addr);
    due_reports.push_back(literal ? literal_res : predicted);
    beats_sent++;
  endtask

  task automatic put_char(input char_t ch);
    send_beat(OP_PUT, ch, lin_out_t'($urandom_range(0, 2047)), 1'b0, '0);
  endtask

  task automatic read_cell(input lin_out_t addr);
    send_beat(OP_READ, char_t'($urandom_range(0, 255)), addr, 1'b0, '0);
  endtask

  // Wait for every report to arrive and for the block to drop busy
  task automatic wait_console_idle();
    while (due_reports.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_palette(input colors_t p);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEXT_HI;
    cfg_data  <= p.text_hi;
    @(posedge clk);
    cfg_index <= CFG_TEXT_LO;
    cfg_data  <= p.text_lo;
    @(posedge clk);
    cfg_index <= CFG_BLANK_HI;
    cfg_data  <= p.blank_hi;
    @(posedge clk);
    cfg_index <= CFG_BLANK_LO;
    cfg_data  <= p.blank_lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    pal = p;
  endtask

  // Bursts of console traffic: text lines, tabbed columns, read-back, blank lines, noise
  task automatic run_phase(input int beats);
    int    stop_at;
    int    kind;
    int    len;
    int    k;
    char_t ch;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = $urandom_range(1, 90);
        for (k = 0; k < len; k++) put_char(char_t'($urandom_range(32, 255)));
        if ($urandom_range(9) < 7) put_char(CH_NL);
      end else if (kind < 50) begin
        len = $urandom_range(1, 20);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) < 4) put_char(CH_TAB);
          else put_char(char_t'($urandom_range(32, 255)));
        end
        put_char($urandom_range(1) ? CH_CR : CH_NL);
      end else if (kind < 78) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
              read_cell(lin_out_t'(cur_row * COLS + $urandom_range(0, COLS - 1)));
            6, 7, 8:
              read_cell(lin_out_t'($urandom_range(0, CELLS - 1)));
            default:
              read_cell(lin_out_t'($urandom_range(0, 2047)));
          endcase
        end
      end else if (kind < 83) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) put_char(CH_NL);
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          ch = char_t'($urandom_range(0, 255));
          if ($urandom_range(1)) put_char(ch);
          else send_beat(OP_READ, ch, lin_out_t'($urandom_range(0, 2047)), 1'b0, '0);
        end
      end
    end
  endtask

  // Compare each report beat with the oldest queued expectation
  always @(posedge clk) begin : check_reports
    result_t due;
    if (rst_n && out_strobe) begin
      if (due_reports.size() == 0) begin
        report_mismatch("report with nothing pending", out_cursor_linear, 0);
      end else begin
        due = due_reports.pop_front();
        if (out_cell_data !== due.cell_data)
          report_mismatch("cell_data", out_cell_data, due.cell_data);
        if (out_cursor_row !== due.cursor_row)
          report_mismatch("cursor_row", out_cursor_row, due.cursor_row);
        if (out_cursor_column !== due.cursor_column)
          report_mismatch("cursor_column", out_cursor_column, due.cursor_column);
        if (out_cursor_linear !== due.cursor_linear)
          report_mismatch("cursor_linear", out_cursor_linear, due.cursor_linear);
        if (out_echo_char !== due.echo_char)
          report_mismatch("echo_char", out_echo_char, due.echo_char);
        if (out_echo_valid !== due.echo_valid)
          report_mismatch("echo_valid", out_echo_valid, due.echo_valid);
      end
    end
  end

  initial begin : stimulus
    colors_t   pals [NUM_PALS];
    stim_row_t srow;
    result_t   lit;
    int        i;

    pals[0] = 16'hFFFF;
    pals[1] = 16'h0000;
    pals[2] = 16'hF00F;
    pals[3] = 16'h3A5C;
    pals[4] = colors_t'($urandom_range(0, 65535));
    pals[5] = colors_t'($urandom_range(0, 65535));

    // Shadow state after reset: cleared screen, reset colors
    pal     = {RST_HI, RST_LO, RST_HI, RST_LO};
    cur_row = 0;
    cur_col = 0;
    for (i = 0; i < CELLS; i++) screen[i] = CLEAR_CELL;
    gaps_on = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Let the clearing pass finish
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed table at reset colors
    for (i = 0; i < DIR_ROWS; i++) begin
      srow = DIR_TAB[i];
      lit  = {srow.want_cell, srow.row, srow.col, lin_out_t'(srow.row * COLS + srow.col),
              srow.ch, srow.op == OP_PUT};
      send_beat(srow.op, srow.ch, srow.addr, srow.literal, lit);
    end
    start <= 1'b0;
    wait_console_idle();

    // Random bursts, one color setting per phase; one phase runs without gaps
    for (i = 0; i < NUM_PALS; i++) begin
      write_palette(pals[i]);
      gaps_on = (i != 3);
      run_phase(PHASE_BEATS);
      start <= 1'b0;
      wait_console_idle();
    end

    // Watch for stray reports over one scroll length
    repeat (CELLS + 16) @(posedge clk);

    $display("Ran %0d beats (%0d puts, %0d reads) over %0d color settings, %0d scrolls.",
             beats_sent, n_put, n_read, NUM_PALS + 1, n_scroll);
    $display("Tab wraps %0d, bottom-row newlines %0d, out-of-range reads %0d, mismatches %0d.",
             n_tab_wrap, n_bottom_nl, n_oob, errors);
    if (errors == 0) begin
      $display("text_console_writer test passed");
    end else begin
      $display("text_console_writer test failed");
    end
    $finish;
  end

endmodule

/* text_console_writer.f */
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_fbuf.sv
sv/tcw_seq.sv
sv/text_console_writer.sv
sv/tcw_chk.sv
dv/text_console_writer_tb.sv
